[design/fsgc_pkg.sv]
// fsgc_pkg: shared types and constants of the four-stop gradient color block.
// No dependencies; used by every module under design/.
package fsgc_pkg;

  localparam int StopCount = 4;
  localparam int SegCount  = StopCount - 1;
  localparam int ChanCount = 4;
  localparam int CfgIdxW   = $clog2(StopCount);

  localparam int RegW   = 41;
  localparam int IdxW   = 8;
  localparam int PosW   = 9;
  localparam int PosLsb = 32;
  localparam int ChanW  = 8;
  localparam int ChanMax = 255;

  // offset and length are signed, one bit wider than a stop position
  localparam int OffW  = PosW + 1;
  localparam int DiffW = ChanW + 1;
  localparam int ProdW = OffW + DiffW;
  // |product| < 2^17; one spare zero bit makes the width a multiple of the step count
  localparam int QuotW = 18;
  localparam int DivW  = PosW;
  localparam int DivStepsPerStage = 3;
  localparam int DivStages = QuotW / DivStepsPerStage;
  localparam int SumW = QuotW + 2;

  // select, multiply, divider stages, finish
  localparam int NumStages = 2 + DivStages + 1;

  localparam logic [RegW-1:0] StopZeroReset  = 41'd4294962615;
  localparam logic [RegW-1:0] StopOneReset   = 41'd399431093561;
  localparam logic [RegW-1:0] StopTwoReset   = 41'd777386162461;
  localparam logic [RegW-1:0] StopThreeReset = 41'd1099523764484;

  typedef logic [StopCount-1:0][RegW-1:0] stops_t;

  typedef struct packed {
    logic [OffW-1:0]                    offset;
    logic [OffW-1:0]                    length;
    logic [ChanCount-1:0][ChanW-1:0]    c0;
    logic [ChanCount-1:0][DiffW-1:0]    diff;
  } sel_t;

  typedef struct packed {
    logic [ChanW-1:0] c0;
    logic             neg;
    logic [DivW-1:0]  rem;
    logic [QuotW-1:0] dq;
  } lane_t;

  typedef struct packed {
    logic [DivW-1:0]             divisor;
    lane_t [ChanCount-1:0]       lane;
  } div_t;

endpackage

[design/fsgc_select.sv]
// fsgc_select: segment search and first pipeline register (offset, length, channel deltas).
// Depends on fsgc_pkg.
module fsgc_select (
  input  logic                             clk,
  input  logic                             load,
  input  logic [fsgc_pkg::IdxW-1:0]        color_index,
  input  fsgc_pkg::stops_t                 stops,
  output fsgc_pkg::sel_t                   sel
);

  logic [fsgc_pkg::StopCount-1:0][fsgc_pkg::PosW-1:0] pos;
  logic [fsgc_pkg::SegCount-1:0]                      hit;
  logic [fsgc_pkg::RegW-1:0]                          stop_a;
  logic [fsgc_pkg::RegW-1:0]                          stop_b;
  logic [fsgc_pkg::PosW-1:0]                          idx_ext;
  fsgc_pkg::sel_t                                     sel_next;

  assign idx_ext = {1'b0, color_index};

  always_comb begin
    for (int k = 0; k < fsgc_pkg::StopCount; k++) begin
      pos[k] = stops[k][fsgc_pkg::PosLsb +: fsgc_pkg::PosW];
    end
    for (int k = 0; k < fsgc_pkg::SegCount; k++) begin
      hit[k] = (idx_ext >= pos[k]) && (idx_ext < pos[k+1]);
    end
  end

  // first matching segment wins; no match falls back to the last one
  always_comb begin
    stop_a = stops[fsgc_pkg::SegCount-1];
    stop_b = stops[fsgc_pkg::SegCount];
    for (int k = fsgc_pkg::SegCount - 1; k >= 0; k--) begin
      if (hit[k]) begin
        stop_a = stops[k];
        stop_b = stops[k+1];
      end
    end
  end

  always_comb begin
    sel_next.offset = {2'b00, color_index}
                    - {1'b0, stop_a[fsgc_pkg::PosLsb +: fsgc_pkg::PosW]};
    sel_next.length = {1'b0, stop_b[fsgc_pkg::PosLsb +: fsgc_pkg::PosW]}
                    - {1'b0, stop_a[fsgc_pkg::PosLsb +: fsgc_pkg::PosW]};
    for (int c = 0; c < fsgc_pkg::ChanCount; c++) begin
      sel_next.c0[c]   = stop_a[fsgc_pkg::ChanW*c +: fsgc_pkg::ChanW];
      sel_next.diff[c] = {1'b0, stop_b[fsgc_pkg::ChanW*c +: fsgc_pkg::ChanW]}
                       - {1'b0, stop_a[fsgc_pkg::ChanW*c +: fsgc_pkg::ChanW]};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sel <= sel_next;
    end
  end

endmodule

[design/fsgc_mult.sv]
// fsgc_mult: signed offset x delta products, split into sign and magnitude for the divider.
// Depends on fsgc_pkg.
module fsgc_mult (
  input  logic            clk,
  input  logic            load,
  input  fsgc_pkg::sel_t  sel,
  output fsgc_pkg::div_t  dv
);

  logic signed [fsgc_pkg::ProdW-1:0] prod [fsgc_pkg::ChanCount];
  logic        [fsgc_pkg::ProdW-1:0] prod_abs [fsgc_pkg::ChanCount];
  logic        [fsgc_pkg::OffW-1:0]  len_abs;
  logic                              len_zero;
  logic                              len_neg;
  fsgc_pkg::div_t                    dv_next;

  assign len_neg  = sel.length[fsgc_pkg::OffW-1];
  assign len_zero = (sel.length == '0);
  assign len_abs  = len_neg ? fsgc_pkg::OffW'(-sel.length) : sel.length;

  always_comb begin
    // zero-length segment: quotient forced to zero, start color passes through
    dv_next.divisor = len_zero ? fsgc_pkg::DivW'(1) : len_abs[fsgc_pkg::DivW-1:0];
    for (int c = 0; c < fsgc_pkg::ChanCount; c++) begin
      prod[c]     = $signed(sel.offset) * $signed(sel.diff[c]);
      prod_abs[c] = prod[c][fsgc_pkg::ProdW-1] ? fsgc_pkg::ProdW'(-prod[c])
                                                 : fsgc_pkg::ProdW'(prod[c]);
      dv_next.lane[c].c0  = sel.c0[c];
      dv_next.lane[c].neg = prod[c][fsgc_pkg::ProdW-1] ^ len_neg;
      dv_next.lane[c].rem = '0;
      dv_next.lane[c].dq  = len_zero ? '0 : prod_abs[c][fsgc_pkg::QuotW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dv <= dv_next;
    end
  end

endmodule

[design/fsgc_div_stage.sv]
// fsgc_div_stage: a few restoring-division steps on all four channel lanes, registered.
// Depends on fsgc_pkg.
module fsgc_div_stage (
  input  logic            clk,
  input  logic            load,
  input  fsgc_pkg::div_t  d_in,
  output fsgc_pkg::div_t  d_out
);

  fsgc_pkg::div_t d_next;

  // dq shifts the dividend out at the top and the quotient in at the bottom
  always_comb begin
    logic [fsgc_pkg::DivW:0]   t;
    logic [fsgc_pkg::DivW-1:0] rem;
    logic [fsgc_pkg::QuotW-1:0] dq;
    logic                      qb;
    d_next = d_in;
    for (int c = 0; c < fsgc_pkg::ChanCount; c++) begin
      rem = d_in.lane[c].rem;
      dq  = d_in.lane[c].dq;
      for (int s = 0; s < fsgc_pkg::DivStepsPerStage; s++) begin
        t = {rem, dq[fsgc_pkg::QuotW-1]};
        if (t >= {1'b0, d_in.divisor}) begin
          rem = fsgc_pkg::DivW'(t - {1'b0, d_in.divisor});
          qb  = 1'b1;
        end else begin
          rem = t[fsgc_pkg::DivW-1:0];
          qb  = 1'b0;
        end
        dq = {dq[fsgc_pkg::QuotW-2:0], qb};
      end
      d_next.lane[c].rem = rem;
      d_next.lane[c].dq  = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_out <= d_next;
    end
  end

endmodule

[design/fsgc_finish.sv]
// fsgc_finish: sign the quotient, add the start color, saturate, output register.
// Depends on fsgc_pkg.
module fsgc_finish (
  input  logic                        clk,
  input  logic                        load,
  input  fsgc_pkg::div_t              dv,
  output logic [fsgc_pkg::ChanW-1:0]  alpha,
  output logic [fsgc_pkg::ChanW-1:0]  red,
  output logic [fsgc_pkg::ChanW-1:0]  green,
  output logic [fsgc_pkg::ChanW-1:0]  blue
);

  logic [fsgc_pkg::ChanCount-1:0][fsgc_pkg::ChanW-1:0] chan_next;

  always_comb begin
    logic signed [fsgc_pkg::SumW-1:0] q;
    logic signed [fsgc_pkg::SumW-1:0] v;
    for (int c = 0; c < fsgc_pkg::ChanCount; c++) begin
      q = $signed({2'b00, dv.lane[c].dq});
      v = $signed({{(fsgc_pkg::SumW - fsgc_pkg::ChanW){1'b0}}, dv.lane[c].c0})
        + (dv.lane[c].neg ? -q : q);
      if (v < 0) begin
        chan_next[c] = '0;
      end else if (v > fsgc_pkg::SumW'(fsgc_pkg::ChanMax)) begin
        chan_next[c] = fsgc_pkg::ChanW'(fsgc_pkg::ChanMax);
      end else begin
        chan_next[c] = v[fsgc_pkg::ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      alpha <= chan_next[3];
      red   <= chan_next[2];
      green <= chan_next[1];
      blue  <= chan_next[0];
    end
  end

endmodule

[design/four_stop_gradient_color.sv]
// four_stop_gradient_color: four-stop linear ARGB gradient lookup, fully pipelined.
// Depends on fsgc_pkg, fsgc_select, fsgc_mult, fsgc_div_stage, fsgc_finish.
//
// Usage:
//   Input channel (in_valid/in_ready/color_index) takes one 8-bit palette index per item.
//   Output channel (out_valid/out_ready/alpha/red/green/blue) returns one ARGB item each.
//   Stops live in four 41-bit registers written via cfg_write/cfg_index/cfg_data:
//   index in bits 40:32, then alpha, red, green, blue bytes. Write only while idle.
// Pipeline:
//   9 register stages: segment select, multiply, 6 divider stages of 3 quotient
//   bits each (18-bit restoring division, four channel lanes), sign/add/saturate.
//   One item per clock is sustained while out_ready stays high.
// Stalls:
//   Each stage carries a valid bit and loads when empty or when the stage after it
//   moves, so bubbles collapse and the input keeps flowing until the pipe is full.
//   No item is lost or repeated while out_ready is low.
// Reset:
//   rst (synchronous) empties the pipe and reloads the default stops.
module four_stop_gradient_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsgc_pkg::IdxW-1:0]     color_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsgc_pkg::ChanW-1:0]    alpha,
  output logic [fsgc_pkg::ChanW-1:0]    red,
  output logic [fsgc_pkg::ChanW-1:0]    green,
  output logic [fsgc_pkg::ChanW-1:0]    blue,
  input  logic                          cfg_write,
  input  logic [fsgc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fsgc_pkg::RegW-1:0]     cfg_data
);

  localparam int Last = fsgc_pkg::NumStages - 1;

  fsgc_pkg::stops_t                  stops;
  logic [fsgc_pkg::NumStages-1:0]    vld;
  logic [fsgc_pkg::NumStages-1:0]    en;
  fsgc_pkg::sel_t                    sel;
  fsgc_pkg::div_t                    dv [fsgc_pkg::DivStages + 1];

  // stop registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stops[0] <= fsgc_pkg::StopZeroReset;
      stops[1] <= fsgc_pkg::StopOneReset;
      stops[2] <= fsgc_pkg::StopTwoReset;
      stops[3] <= fsgc_pkg::StopThreeReset;
    end else if (cfg_write) begin
      stops[cfg_index] <= cfg_data;
    end
  end

  // a stage loads when it is empty or its item moves on
  always_comb begin
    en[Last] = !vld[Last] || out_ready;
    for (int i = Last - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < fsgc_pkg::NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[Last];

  fsgc_select u_select (
    .clk         (clk),
    .load        (en[0]),
    .color_index (color_index),
    .stops       (stops),
    .sel         (sel)
  );

  fsgc_mult u_mult (
    .clk  (clk),
    .load (en[1]),
    .sel  (sel),
    .dv   (dv[0])
  );

  for (genvar j = 0; j < fsgc_pkg::DivStages; j++) begin : g_div
    fsgc_div_stage u_div (
      .clk   (clk),
      .load  (en[2+j]),
      .d_in  (dv[j]),
      .d_out (dv[j+1])
    );
  end

  fsgc_finish u_finish (
    .clk   (clk),
    .load  (en[Last]),
    .dv    (dv[fsgc_pkg::DivStages]),
    .alpha (alpha),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

endmodule

[tb/tb_four_stop_gradient_color.sv]
`timescale 1ns / 100ps
// tb_four_stop_gradient_color: self-checking testbench of the four-stop ARGB gradient.
// Depends on fsgc_pkg and four_stop_gradient_color, and through it on that block's submodules.
module tb_four_stop_gradient_color;

  // pipe depth quoted by the block's header; also bounds the final drain
  localparam int PipeLatency   = 9;
  // cycles in a row without any item moving before the run is declared hung
  localparam int StallLimit    = 5000;
  localparam int RandomPhases  = 6;
  localparam int ItemsPerPhase = 300;

  // channel 3 = alpha ... channel 0 = blue, same order as the stop packing
  typedef logic [fsgc_pkg::ChanCount-1:0][fsgc_pkg::ChanW-1:0] argb_t;

  typedef enum logic [fsgc_pkg::CfgIdxW-1:0] {
    STOP_ZERO_REG,
    STOP_ONE_REG,
    STOP_TWO_REG,
    STOP_THREE_REG
  } stop_reg_t;

  // directed rows: a stop write, an index checked by the predictor, or an
  // index whose color is typed in
  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    stop_reg_t                   sel;
    logic [fsgc_pkg::RegW-1:0]   word;
    logic [fsgc_pkg::IdxW-1:0]   idx;
    argb_t                       known;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [fsgc_pkg::IdxW-1:0]      color_index = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [fsgc_pkg::ChanW-1:0]     alpha, red, green, blue;
  logic                           cfg_write = 1'b0;
  logic [fsgc_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [fsgc_pkg::RegW-1:0]      cfg_data = '0;

  // testbench copy of the stop registers, updated with every write
  logic [fsgc_pkg::RegW-1:0]  stop_regs [fsgc_pkg::StopCount];
  // colors still owed by the block, oldest first
  argb_t            pending_argb [$];
  int               errors = 0;
  int               idle_cycles = 0;
  int               send_gap_pct = 17;
  int               recv_stall_pct = 46;
  string            chan_name [fsgc_pkg::ChanCount] = '{"blue", "green", "red", "alpha"};

  four_stop_gradient_color u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .color_index (color_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .alpha       (alpha),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected color of one palette index under the current stops.
  // First segment with start <= idx < end wins; if none, the last segment
  // is used even when its stops are out of order (negative span).
  // Zero span gives the start color; channels clamp to 0..255.
  function automatic argb_t blend_color(input logic [fsgc_pkg::IdxW-1:0] idx);
    int    pos [fsgc_pkg::StopCount];
    int    seg;
    int    offset;
    int    span;
    int    c0;
    int    c1;
    int    v;
    bit    found;
    argb_t res;
    for (int k = 0; k < fsgc_pkg::StopCount; k++) begin
      pos[k] = int'(stop_regs[k][fsgc_pkg::RegW-1:fsgc_pkg::PosLsb]);
    end
    seg   = fsgc_pkg::SegCount - 1;
    found = 1'b0;
    for (int k = 0; k < fsgc_pkg::SegCount; k++) begin
      if (!found && int'(idx) >= pos[k] && int'(idx) < pos[k+1]) begin
        seg   = k;
        found = 1'b1;
      end
    end
    offset = int'(idx) - pos[seg];
    span   = pos[seg+1] - pos[seg];
    for (int ch = 0; ch < fsgc_pkg::ChanCount; ch++) begin
      c0 = int'(stop_regs[seg][ch*fsgc_pkg::ChanW +: fsgc_pkg::ChanW]);
      c1 = int'(stop_regs[seg+1][ch*fsgc_pkg::ChanW +: fsgc_pkg::ChanW]);
      // SV signed division truncates toward zero, as the block must
      v = (span == 0) ? c0 : c0 + (offset * (c1 - c0)) / span;
      if (v < 0) v = 0;
      if (v > fsgc_pkg::ChanMax) v = fsgc_pkg::ChanMax;
      res[ch] = v[fsgc_pkg::ChanW-1:0];
    end
    return res;
  endfunction

  function automatic stim_row_t table_row(input row_kind_t kind, input stop_reg_t sel,
                                          input logic [fsgc_pkg::PosW-1:0] pos,
                                          input logic [31:0] argb,
                                          input logic [fsgc_pkg::IdxW-1:0] idx);
    stim_row_t r;
    r.kind  = kind;
    r.sel   = sel;
    r.word  = {pos, argb};
    r.idx   = idx;
    r.known = argb;
    return r;
  endfunction

  // Entered and left at a falling edge. Optional gap, then valid held
  // until accepted; the expectation is queued at the accepting edge.
  task automatic push_index(input logic [fsgc_pkg::IdxW-1:0] idx, input bit use_known,
                            input argb_t known);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    color_index = idx;
    do @(posedge clk); while (!in_ready);
    pending_argb.push_back(use_known ? known : blend_color(idx));
    @(negedge clk);
  endtask

  // stop writes are only legal with the pipe empty
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_argb.size() != 0) @(negedge clk);
  endtask

  task automatic write_stop(input stop_reg_t sel, input logic [fsgc_pkg::RegW-1:0] word);
    cfg_write = 1'b1;
    cfg_index = sel;
    cfg_data  = word;
    @(negedge clk);
    cfg_write      = 1'b0;
    stop_regs[sel] = word;
  endtask

  // receiver: random back-pressure, decided at the falling edge
  always @(negedge clk) begin
    out_ready = !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker: every accepted color against the oldest expectation
  always @(posedge clk) begin : check_colors
    argb_t got;
    argb_t want;
    if (!rst && out_valid && out_ready) begin
      got = {alpha, red, green, blue};
      if (pending_argb.size() == 0) begin
        errors++;
        $display("%0t: color %h with none expected", $time, got);
      end else begin
        want = pending_argb.pop_front();
        for (int ch = fsgc_pkg::ChanCount - 1; ch >= 0; ch--) begin
          if (got[ch] !== want[ch]) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, chan_name[ch], want[ch], got[ch]);
          end
        end
      end
    end
  end

  // watchdog: a long stretch with no item moving on either side is a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t                  directed_rows [$];
    logic [fsgc_pkg::PosW-1:0]  pos [fsgc_pkg::StopCount];
    logic [fsgc_pkg::PosW-1:0]  t;
    int                         near;
    int                         k;
    logic [fsgc_pkg::IdxW-1:0]  idx;

    stop_regs[0] = fsgc_pkg::StopZeroReset;
    stop_regs[1] = fsgc_pkg::StopOneReset;
    stop_regs[2] = fsgc_pkg::StopTwoReset;
    stop_regs[3] = fsgc_pkg::StopThreeReset;

    // Default stops: the colors at the stop indexes read straight off the
    // reset values; in-between points go through the predictor.
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'hFFFFEDB7, 8'd0));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'hFFF2CD39, 8'd92));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'hFFD3791D, 8'd180));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd255));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd91));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd179));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd1));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd128));
    // Extremes: empty first segment, then 0..511 white to black.
    // Index 0 skips the empty segment and lands on the second stop.
    directed_rows.push_back(table_row(ROW_WRITE, STOP_ZERO_REG,  9'd0,   32'h00000000, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_ONE_REG,   9'd0,   32'hFFFFFFFF, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_TWO_REG,   9'd511, 32'h00000000, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_THREE_REG, 9'd511, 32'hFFFFFFFF, 8'd0));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'hFFFFFFFF, 8'd0));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd255));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd170));
    // Index past every segment with an empty last segment: start color.
    directed_rows.push_back(table_row(ROW_WRITE, STOP_ONE_REG,   9'd50,  32'hFFFFFFFF, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_TWO_REG,   9'd100, 32'h5A3CC396, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_THREE_REG, 9'd100, 32'hFFFFFFFF, 8'd0));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'h5A3CC396, 8'd200));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'h5A3CC396, 8'd255));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'h5A3CC396, 8'd100));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd75));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd49));
    // Stops out of order: fallback segment 200 -> 100 has a negative span.
    // Index 50 overshoots by half again and index 255 runs backward, so
    // every channel clamps at 0 or 255.
    directed_rows.push_back(table_row(ROW_WRITE, STOP_ZERO_REG,  9'd300, 32'h80808080, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_ONE_REG,   9'd400, 32'h11223344, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_TWO_REG,   9'd200, 32'h00FF00FF, 8'd0));
    directed_rows.push_back(table_row(ROW_WRITE, STOP_THREE_REG, 9'd100, 32'hFF00FF00, 8'd0));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'hFF00FF00, 8'd50));
    directed_rows.push_back(table_row(ROW_KNOWN,   STOP_ZERO_REG, '0, 32'h00FF00FF, 8'd255));
    // 150 halves a negative span: checks truncation toward zero
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd150));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd0));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd199));
    directed_rows.push_back(table_row(ROW_PREDICT, STOP_ZERO_REG, '0, 32'h0, 8'd200));

    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      unique case (directed_rows[r].kind)
        ROW_WRITE: begin
          wait_drained();
          write_stop(directed_rows[r].sel, directed_rows[r].word);
        end
        ROW_KNOWN: push_index(directed_rows[r].idx, 1'b1, directed_rows[r].known);
        default:   push_index(directed_rows[r].idx, 1'b0, '0);
      endcase
    end

    // Random phases, each under fresh stops. Idling: sender light and
    // receiver heavy, then the reverse, then both sides flat out.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_drained();
      send_gap_pct   = (ph < 2) ? 17 : (ph < 4) ? 46 : 0;
      recv_stall_pct = (ph < 2) ? 46 : (ph < 4) ? 17 : 0;
      // mostly ordered stops in 0..300, now and then anywhere
      // in 0..511 and unordered, sometimes an empty segment
      for (k = 0; k < fsgc_pkg::StopCount; k++) begin
        pos[k] = ($urandom_range(0, 9) < 7) ? fsgc_pkg::PosW'($urandom_range(0, 300))
                                             : fsgc_pkg::PosW'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 9) < 7) begin
        for (int i = 0; i < fsgc_pkg::StopCount - 1; i++) begin
          for (int j = 0; j < fsgc_pkg::StopCount - 1 - i; j++) begin
            if (pos[j] > pos[j+1]) begin
              t        = pos[j];
              pos[j]   = pos[j+1];
              pos[j+1] = t;
            end
          end
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        k          = $urandom_range(0, fsgc_pkg::SegCount - 1);
        pos[k + 1] = pos[k];
      end
      for (k = 0; k < fsgc_pkg::StopCount; k++) begin
        write_stop(stop_reg_t'(k), {pos[k], 32'($urandom())});
      end

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // a fifth of the indexes sit right around a stop boundary
        if ($urandom_range(0, 4) == 0) begin
          near = int'(pos[$urandom_range(0, fsgc_pkg::StopCount - 1)])
               + int'($urandom_range(0, 4)) - 2;
          if (near < 0) near = 0;
          if (near > 255) near = 255;
          idx = near[fsgc_pkg::IdxW-1:0];
        end else begin
          idx = fsgc_pkg::IdxW'($urandom_range(0, 255));
        end
        push_index(idx, 1'b0, '0);
      end
    end

    wait_drained();
    // let any stray extra result show up
    repeat (2 * PipeLatency) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
